>>> rtl/bldc_hall_commutation_controller_core_macros.svh
// assertion macros for the hall commutation controller
`ifndef BLDC_HALL_COMMUTATION_CONTROLLER_CORE_MACROS_SVH
`define BLDC_HALL_COMMUTATION_CONTROLLER_CORE_MACROS_SVH

`ifndef SYNTH

// antecedent holds, consequent holds in the same cycle
`define BHCC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent holds, consequent holds in the next cycle
`define BHCC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define BHCC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define BHCC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

>>> rtl/bhcc_pkg.sv
// shared types and constants of the hall commutation controller
package bhcc_pkg;

   // block average lengths, powers of two
   localparam int POT_AVG_LEN  = 16;
   localparam int VBUS_AVG_LEN = 64;

   localparam int POT_SHIFT  = $clog2(POT_AVG_LEN);
   localparam int VBUS_SHIFT = $clog2(VBUS_AVG_LEN);
   localparam int POT_SUM_W  = 12 + POT_SHIFT;
   localparam int VBUS_SUM_W = 12 + VBUS_SHIFT;
   localparam int POT_CNT_W  = POT_SHIFT + 1;
   localparam int VBUS_CNT_W = VBUS_SHIFT + 1;

   localparam logic [15:0] DUTY_FULL_RST  = 16'd3200;
   localparam logic [15:0] DUTY_FLOOR_RST = 16'd200;
   localparam logic [15:0] PRECHARGE_RST  = 16'd2000;

   localparam logic [15:0] DEAD_ZONE = 16'd200;
   localparam logic [15:0] TOP_CLAMP = 16'd3136;
   localparam logic [15:0] STALL_MAX = 16'd65535;

   // register indexes
   localparam logic [1:0] CSR_DUTY_FULL  = 2'd0;
   localparam logic [1:0] CSR_DUTY_FLOOR = 2'd1;
   localparam logic [1:0] CSR_PRECHARGE  = 2'd2;

   // drive modes
   localparam logic [1:0] MODE_OFF  = 2'd0;
   localparam logic [1:0] MODE_LOW  = 2'd1;
   localparam logic [1:0] MODE_COMM = 2'd2;

   // sequencer state codes as reported on the result word
   localparam logic [1:0] SEQ_CODE_OFF       = 2'd0;
   localparam logic [1:0] SEQ_CODE_START     = 2'd1;
   localparam logic [1:0] SEQ_CODE_PRECHARGE = 2'd2;
   localparam logic [1:0] SEQ_CODE_RUN       = 2'd3;

   localparam logic [2:0] HALL_ALL_LOW  = 3'd0;
   localparam logic [2:0] HALL_ALL_HIGH = 3'd7;

   typedef enum logic [3:0] {
      SEQ_OFF       = 4'b0001,
      SEQ_START     = 4'b0010,
      SEQ_PRECHARGE = 4'b0100,
      SEQ_RUN       = 4'b1000
   } seq_type;

   typedef struct packed {
      logic [2:0]  hall_first;
      logic [2:0]  hall_second;
      logic [2:0]  hall_third;
      logic [11:0] pot_sample;
      logic [11:0] vbus_sample;
      logic        stop_request;
      logic        fault_active;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  drive_mode;
      logic [2:0]  commutation_index;
      logic [15:0] duty;
      logic [11:0] vbus_average;
      logic        hall_error;
      logic [1:0]  sequencer_state;
      logic        motor_running;
   } rsp_word_type;

   // filter results after the current word
   typedef struct packed {
      logic [11:0] pot_filtered;
      logic [11:0] vbus_avg;
   } filt_type;

endpackage

>>> rtl/bhcc_if.sv
// channel interfaces of the hall commutation controller
interface bhcc_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  hall_first;
   logic [2:0]  hall_second;
   logic [2:0]  hall_third;
   logic [11:0] pot_sample;
   logic [11:0] vbus_sample;
   logic        stop_request;
   logic        fault_active;

   modport source (output valid, hall_first, hall_second, hall_third, pot_sample,
                   vbus_sample, stop_request, fault_active, input ready);
   modport sink (input valid, hall_first, hall_second, hall_third, pot_sample,
                 vbus_sample, stop_request, fault_active, output ready);
endinterface

interface bhcc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  drive_mode;
   logic [2:0]  commutation_index;
   logic [15:0] duty;
   logic [11:0] vbus_average;
   logic        hall_error;
   logic [1:0]  sequencer_state;
   logic        motor_running;

   modport source (output valid, drive_mode, commutation_index, duty, vbus_average,
                   hall_error, sequencer_state, motor_running, input ready);
   modport sink (input valid, drive_mode, commutation_index, duty, vbus_average,
                 hall_error, sequencer_state, motor_running, output ready);
endinterface

interface bhcc_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/bhcc_filters.sv
// block averages of the pot and bus voltage samples
module bhcc_filters (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [11:0]          pot_sample,
   input  logic [11:0]          vbus_sample,
   output bhcc_pkg::filt_type   filt
);

   logic [bhcc_pkg::POT_SUM_W-1:0]  pot_sum_ff, pot_sum_in, pot_acc;
   logic [bhcc_pkg::POT_CNT_W-1:0]  pot_cnt_ff, pot_cnt_in, pot_cnt_inc;
   logic [11:0]                     pot_filt_ff, pot_filt_in;
   logic [bhcc_pkg::VBUS_SUM_W-1:0] vbus_sum_ff, vbus_sum_in, vbus_acc;
   logic [bhcc_pkg::VBUS_CNT_W-1:0] vbus_cnt_ff, vbus_cnt_in, vbus_cnt_inc;
   logic [11:0]                     vbus_avg_ff, vbus_avg_in;

   always_comb begin
      pot_acc     = pot_sum_ff + bhcc_pkg::POT_SUM_W'(pot_sample);
      pot_cnt_inc = pot_cnt_ff + bhcc_pkg::POT_CNT_W'(1);
      pot_sum_in  = pot_acc;
      pot_cnt_in  = pot_cnt_inc;
      pot_filt_in = pot_filt_ff;
      if (pot_cnt_inc >= bhcc_pkg::POT_CNT_W'(bhcc_pkg::POT_AVG_LEN)) begin
         pot_filt_in = 12'(pot_acc >> bhcc_pkg::POT_SHIFT);
         pot_sum_in  = '0;
         pot_cnt_in  = '0;
      end

      vbus_acc     = vbus_sum_ff + bhcc_pkg::VBUS_SUM_W'(vbus_sample);
      vbus_cnt_inc = vbus_cnt_ff + bhcc_pkg::VBUS_CNT_W'(1);
      vbus_sum_in  = vbus_acc;
      vbus_cnt_in  = vbus_cnt_inc;
      vbus_avg_in  = vbus_avg_ff;
      if (vbus_cnt_inc >= bhcc_pkg::VBUS_CNT_W'(bhcc_pkg::VBUS_AVG_LEN)) begin
         vbus_avg_in = 12'(vbus_acc >> bhcc_pkg::VBUS_SHIFT);
         vbus_sum_in = '0;
         vbus_cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pot_sum_ff  <= '0;
         pot_cnt_ff  <= '0;
         pot_filt_ff <= '0;
         vbus_sum_ff <= '0;
         vbus_cnt_ff <= '0;
         vbus_avg_ff <= '0;
      end else if (advance) begin
         pot_sum_ff  <= pot_sum_in;
         pot_cnt_ff  <= pot_cnt_in;
         pot_filt_ff <= pot_filt_in;
         vbus_sum_ff <= vbus_sum_in;
         vbus_cnt_ff <= vbus_cnt_in;
         vbus_avg_ff <= vbus_avg_in;
      end
   end

   assign filt.pot_filtered = pot_filt_in;
   assign filt.vbus_avg     = vbus_avg_in;

endmodule

>>> rtl/bldc_hall_commutation_controller_core.sv
// top level of the six-step hall commutation controller
//
// One request word per PWM tick on req_if: three hall samples, pot and bus
// voltage conversions, a stop request and a fault flag. Each word produces
// exactly one response word on rsp_if with the drive mode, commutation index,
// duty, bus voltage average, sticky hall error, sequencer state and run flag.
// Registers duty_full, duty_floor and precharge_ticks (indexes 0 to 2) are
// written on csr_if, which is ready whenever reset is low; write them only
// while no word is in flight.
// A word is taken into an input register; from there the whole tick update
// (hall check, sequencer, averages, one 12x16 multiply for the pot scaling,
// run/stop) is combinational and lands in the response register together
// with the state. rsp_if.valid rises once the word has moved from the input
// register to the response register, which waits for a held response to be
// taken. Throughput is one word per cycle while the receiver takes responses.
// When the receiver stalls, the response register holds its word and the
// input register still takes one more word; req_if.ready then drops until
// the response is taken. Reset returns the registers to their defaults and
// all controller state to off, with both stages empty and ready held low.
`include "bldc_hall_commutation_controller_core_macros.svh"

module bldc_hall_commutation_controller_core (
   input  logic       clock,
   input  logic       reset,
   bhcc_req_if.sink   req_if,
   bhcc_rsp_if.source rsp_if,
   bhcc_csr_if.sink   csr_if
);

   // configuration
   logic [15:0] duty_full_ff, duty_floor_ff, precharge_ticks_ff;

   // pipeline control
   logic                   s1_valid_ff, s1_valid_in;
   bhcc_pkg::req_word_type s1_word_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   bhcc_pkg::rsp_word_type rsp_word_ff, rsp_word_in;
   logic                   out_free, step, accept;

   // controller state
   bhcc_pkg::seq_type seq_ff, seq_in;
   logic              run_ff, run_in;
   logic [15:0]       pre_ff, pre_in, pre_upd;
   logic [2:0]        hall_before_ff, hall_before_in;
   logic [15:0]       stall_ff, stall_in;
   logic              err_ff, err_in;
   logic [1:0]        drive_ff, drive_in;
   logic [2:0]        idx_ff, idx_in;
   logic [15:0]       duty_ff, duty_in;
   logic [15:0]       pot_duty_ff, pot_duty_in;

   bhcc_pkg::filt_type filt;

   logic        hall_agree, hall_changed, hall_legal, hall_upd;
   logic [27:0] pot_prod;
   logic [15:0] pot_scaled;
   logic [1:0]  seq_code;

   assign out_free    = !rsp_valid_ff || rsp_if.ready;
   assign step        = s1_valid_ff && out_free;
   assign req_if.ready = !reset && (!s1_valid_ff || step);
   assign accept      = req_if.valid && req_if.ready;
   assign s1_valid_in  = accept || (s1_valid_ff && !step);
   assign rsp_valid_in = step || (rsp_valid_ff && !rsp_if.ready);

   assign csr_if.ready = !reset;

   bhcc_filters u_filters (
      .clock       (clock),
      .reset       (reset),
      .advance     (step),
      .pot_sample  (s1_word_ff.pot_sample),
      .vbus_sample (s1_word_ff.vbus_sample),
      .filt        (filt)
   );

   // hall pattern qualification
   assign hall_agree   = (s1_word_ff.hall_first == s1_word_ff.hall_second) &&
                         (s1_word_ff.hall_second == s1_word_ff.hall_third);
   assign hall_changed = s1_word_ff.hall_third != hall_before_ff;
   assign hall_legal   = (s1_word_ff.hall_third != bhcc_pkg::HALL_ALL_LOW) &&
                         (s1_word_ff.hall_third != bhcc_pkg::HALL_ALL_HIGH);
   assign hall_upd     = hall_agree && hall_changed && hall_legal;

   // pot scaling: (filtered * 16 * duty_full) >> 16
   assign pot_prod   = 28'(filt.pot_filtered) * 28'(duty_full_ff);
   assign pot_scaled = pot_prod[27:12];

   always_comb begin
      if (pot_scaled > bhcc_pkg::TOP_CLAMP) begin
         pot_duty_in = duty_full_ff;
      end else if (pot_scaled < bhcc_pkg::DEAD_ZONE) begin
         pot_duty_in = '0;
      end else begin
         pot_duty_in = pot_scaled;
      end
   end

   always_comb begin
      seq_in         = seq_ff;
      pre_upd        = pre_ff;
      hall_before_in = hall_before_ff;
      stall_in       = stall_ff;
      err_in         = err_ff;
      drive_in       = drive_ff;
      idx_in         = idx_ff;
      duty_in        = duty_ff;

      case (seq_ff)
         bhcc_pkg::SEQ_OFF: begin
            drive_in       = bhcc_pkg::MODE_OFF;
            idx_in         = '0;
            duty_in        = duty_floor_ff;
            stall_in       = '0;
            hall_before_in = '0;
         end
         bhcc_pkg::SEQ_START: begin
            drive_in = bhcc_pkg::MODE_LOW;
            idx_in   = '0;
            pre_upd  = precharge_ticks_ff;
            seq_in   = bhcc_pkg::SEQ_PRECHARGE;
         end
         bhcc_pkg::SEQ_PRECHARGE: begin
            if (pre_ff == '0) begin
               duty_in = pot_duty_ff;
               seq_in  = bhcc_pkg::SEQ_RUN;
               if (hall_agree && hall_changed) begin
                  hall_before_in = s1_word_ff.hall_third;
                  if (!hall_legal) begin
                     err_in = 1'b1;
                  end
               end
               if (hall_upd) begin
                  drive_in = bhcc_pkg::MODE_COMM;
                  idx_in   = s1_word_ff.hall_third;
               end else begin
                  drive_in = bhcc_pkg::MODE_OFF;
                  idx_in   = '0;
               end
            end
         end
         bhcc_pkg::SEQ_RUN: begin
            duty_in = pot_duty_ff;
            if (hall_agree && hall_changed) begin
               hall_before_in = s1_word_ff.hall_third;
               if (!hall_legal) begin
                  err_in = 1'b1;
               end
            end
            if (hall_upd) begin
               stall_in = '0;
               drive_in = bhcc_pkg::MODE_COMM;
               idx_in   = s1_word_ff.hall_third;
            end else if (stall_ff < bhcc_pkg::STALL_MAX) begin
               stall_in = stall_ff + 16'd1;
            end else begin
               err_in = 1'b1;
            end
         end
         default: begin
            seq_in = bhcc_pkg::SEQ_OFF;
         end
      endcase

      // precharge countdown
      pre_in = (pre_upd != '0) ? pre_upd - 16'd1 : pre_upd;

      // run/stop decision on the fresh pot duty
      run_in = run_ff;
      if (!run_ff) begin
         if (!s1_word_ff.fault_active && (pot_duty_in >= duty_floor_ff)) begin
            run_in = 1'b1;
            seq_in = bhcc_pkg::SEQ_START;
         end
      end else if (s1_word_ff.stop_request || (pot_duty_in == '0)) begin
         run_in = 1'b0;
         seq_in = bhcc_pkg::SEQ_OFF;
      end
   end

   always_comb begin
      case (seq_in)
         bhcc_pkg::SEQ_OFF:       seq_code = bhcc_pkg::SEQ_CODE_OFF;
         bhcc_pkg::SEQ_START:     seq_code = bhcc_pkg::SEQ_CODE_START;
         bhcc_pkg::SEQ_PRECHARGE: seq_code = bhcc_pkg::SEQ_CODE_PRECHARGE;
         bhcc_pkg::SEQ_RUN:       seq_code = bhcc_pkg::SEQ_CODE_RUN;
         default:                 seq_code = bhcc_pkg::SEQ_CODE_OFF;
      endcase
   end

   always_comb begin
      rsp_word_in.drive_mode        = drive_in;
      rsp_word_in.commutation_index = idx_in;
      rsp_word_in.duty              = duty_in;
      rsp_word_in.vbus_average      = filt.vbus_avg;
      rsp_word_in.hall_error        = err_in;
      rsp_word_in.sequencer_state   = seq_code;
      rsp_word_in.motor_running     = run_in;
   end

   // configuration registers, indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         duty_full_ff       <= bhcc_pkg::DUTY_FULL_RST;
         duty_floor_ff      <= bhcc_pkg::DUTY_FLOOR_RST;
         precharge_ticks_ff <= bhcc_pkg::PRECHARGE_RST;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            bhcc_pkg::CSR_DUTY_FULL:  duty_full_ff       <= csr_if.data;
            bhcc_pkg::CSR_DUTY_FLOOR: duty_floor_ff      <= csr_if.data;
            bhcc_pkg::CSR_PRECHARGE:  precharge_ticks_ff <= csr_if.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_word_ff.hall_first   <= req_if.hall_first;
         s1_word_ff.hall_second  <= req_if.hall_second;
         s1_word_ff.hall_third   <= req_if.hall_third;
         s1_word_ff.pot_sample   <= req_if.pot_sample;
         s1_word_ff.vbus_sample  <= req_if.vbus_sample;
         s1_word_ff.stop_request <= req_if.stop_request;
         s1_word_ff.fault_active <= req_if.fault_active;
      end
      if (step) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff         <= bhcc_pkg::SEQ_OFF;
         run_ff         <= 1'b0;
         pre_ff         <= '0;
         hall_before_ff <= '0;
         stall_ff       <= '0;
         err_ff         <= 1'b0;
         drive_ff       <= bhcc_pkg::MODE_OFF;
         idx_ff         <= '0;
         duty_ff        <= '0;
         pot_duty_ff    <= '0;
      end else if (step) begin
         seq_ff         <= seq_in;
         run_ff         <= run_in;
         pre_ff         <= pre_in;
         hall_before_ff <= hall_before_in;
         stall_ff       <= stall_in;
         err_ff         <= err_in;
         drive_ff       <= drive_in;
         idx_ff         <= idx_in;
         duty_ff        <= duty_in;
         pot_duty_ff    <= pot_duty_in;
      end
   end

   assign rsp_if.valid             = rsp_valid_ff;
   assign rsp_if.drive_mode        = rsp_word_ff.drive_mode;
   assign rsp_if.commutation_index = rsp_word_ff.commutation_index;
   assign rsp_if.duty              = rsp_word_ff.duty;
   assign rsp_if.vbus_average      = rsp_word_ff.vbus_average;
   assign rsp_if.hall_error        = rsp_word_ff.hall_error;
   assign rsp_if.sequencer_state   = rsp_word_ff.sequencer_state;
   assign rsp_if.motor_running     = rsp_word_ff.motor_running;

   // hall error is sticky until reset
   `BHCC_ASSERT_NEXT(a_err_sticky, clock, reset, err_ff, err_ff, "hall error cleared")
   // run flag and a live sequencer go together
   `BHCC_ASSERT_SAME(a_run_seq, clock, reset, 1'b1, run_ff == (seq_ff != bhcc_pkg::SEQ_OFF),
                     "run flag disagrees with sequencer")
   // during precharge the low sides stay on
   `BHCC_ASSERT_SAME(a_pre_low, clock, reset, seq_ff == bhcc_pkg::SEQ_PRECHARGE,
                     drive_ff == bhcc_pkg::MODE_LOW, "precharge without low-side drive")
   // an index is only carried while commutating
   `BHCC_ASSERT_SAME(a_idx_comm, clock, reset, idx_ff != 3'd0,
                     drive_ff == bhcc_pkg::MODE_COMM, "index set outside commutation")

endmodule
